>>> rtl/core/window_coefficient_generator_macros.svh
// Assertion macros for the window coefficient generator.
// Included by the files that carry concurrent checks; needs no package.
`ifndef WINDOW_COEFFICIENT_GENERATOR_MACROS_SVH
`define WINDOW_COEFFICIENT_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/wcg_pkg.sv
// Shared types and constants for the window coefficient generator.
// No dependencies; used by wcg_fill_engine and the top level.
package wcg_pkg;

    localparam int VW       = 36;   // signed Q30 working width
    localparam int DIV_W    = 46;   // long-division dividend width
    localparam int IDX_W    = 12;
    localparam int LEN_W    = 13;
    localparam int IDX_SPAN = 4096; // indices addressable by sample_index

    localparam logic [2:0] WT_HAMMING  = 3'd0;
    localparam logic [2:0] WT_HANN_NZ  = 3'd1;
    localparam logic [2:0] WT_HANN     = 3'd2;
    localparam logic [2:0] WT_BLACKMAN = 3'd3;
    localparam logic [2:0] WT_TRI      = 3'd4;
    localparam logic [2:0] WT_SQRT_TRI = 3'd5;

    localparam logic REG_TYPE   = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    localparam logic [LEN_W-1:0] RESET_LENGTH = 13'd256;

    localparam logic signed [VW-1:0] ONE_Q30 = 36'sd1073741824;
    localparam logic signed [VW-1:0] C_054   = 36'sd579820585;
    localparam logic signed [VW-1:0] C_042   = 36'sd450971566;
    localparam logic signed [VW-1:0] C_008   = 36'sd85899346;

    localparam logic signed [31:0] K_046 = 32'sd493921239;
    localparam logic signed [31:0] K_050 = 32'sd536870912;
    localparam logic signed [31:0] K_008 = 32'sd85899346;

    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_START,
        FS_SETUP,
        FS_DIV,
        FS_CORDIC,
        FS_COS,
        FS_MUL,
        FS_ACC,
        FS_SQRT,
        FS_WRITE
    } fill_state_t;

    typedef struct packed {
        logic busy;
        logic wr_en;
    } fill_stat_t;

    // arctan(2^-k) in turns, 2^32 per turn
    function automatic logic [29:0] atan_turn(input logic [4:0] k);
        logic [29:0] a;
        case (k)
            5'd0:  a = 30'h20000000;
            5'd1:  a = 30'h12E4051E;
            5'd2:  a = 30'h09FB385B;
            5'd3:  a = 30'h051111D4;
            5'd4:  a = 30'h028B0D43;
            5'd5:  a = 30'h0145D7E1;
            5'd6:  a = 30'h00A2F61E;
            5'd7:  a = 30'h00517C55;
            5'd8:  a = 30'h0028BE53;
            5'd9:  a = 30'h00145F2F;
            5'd10: a = 30'h000A2F98;
            5'd11: a = 30'h000517CC;
            5'd12: a = 30'h00028BE6;
            5'd13: a = 30'h000145F3;
            5'd14: a = 30'h0000A2F9;
            5'd15: a = 30'h0000517C;
            5'd16: a = 30'h000028BE;
            5'd17: a = 30'h0000145F;
            5'd18: a = 30'h00000A2F;
            5'd19: a = 30'h00000517;
            5'd20: a = 30'h0000028B;
            5'd21: a = 30'h00000145;
            5'd22: a = 30'h000000A2;
            5'd23: a = 30'h00000051;
            5'd24: a = 30'h00000028;
            5'd25: a = 30'h00000014;
            5'd26: a = 30'h0000000A;
            5'd27: a = 30'h00000005;
            5'd28: a = 30'h00000002;
            5'd29: a = 30'h00000001;
            default: a = 30'h0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/window_coefficient_generator.sv
// Window coefficient generator: APB registers, coefficient table, read pipeline.
// Depends on wcg_pkg, wcg_fill_engine and window_coefficient_generator_macros.svh.
//
// Returns the window coefficient for each requested sample index, one request per
// cycle while no rebuild runs and result_ready does not hold the output, through a
// table read stage and then an output register. The coefficients are held in a
// single-port table of min(MAX_LENGTH, 4096) entries that is rebuilt after reset
// and after every register write; during the rebuild index_ready is low while the
// APB port stays usable. The rebuild computes each entry in turn with a shared
// bit-serial divider, a 30-step CORDIC, one multiplier and a 32-step square root.
// The reset setting is a 256-point Hamming window.
// Indices at or past the window length return zero with index_out_of_range set.
`include "window_coefficient_generator_macros.svh"
module window_coefficient_generator
    import wcg_pkg::*;
#(
    parameter int MAX_LENGTH = 4096,
    parameter int FRAC_BITS  = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               index_valid,
    output logic               index_ready,
    input  logic [IDX_W-1:0]   sample_index,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [FRAC_BITS:0] coefficient,
    output logic               index_out_of_range
);

    localparam int DEPTH = (MAX_LENGTH < IDX_SPAN) ? MAX_LENGTH : IDX_SPAN;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [FRAC_BITS:0] ONE_OUT = {1'b1, {FRAC_BITS{1'b0}}};

    logic [2:0]       window_type_reg;
    logic [LEN_W-1:0] window_length_reg;
    logic [LEN_W-1:0] n_sat;
    logic             cfg_wr;

    fill_stat_t         fill_stat;
    logic [AW-1:0]      fill_addr;
    logic [FRAC_BITS:0] fill_data;

    // coefficient table, one registered read port
    logic [FRAC_BITS:0] coef_mem [DEPTH];
    logic [FRAC_BITS:0] ram_q;

    logic s1_valid_reg, s1_oor_reg;
    logic result_valid_reg, oor_reg;
    logic [FRAC_BITS:0] coefficient_reg;
    logic in_take, out_load, s1_free;

    // --- register port ---
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_type_reg   <= WT_HAMMING;
            window_length_reg <= RESET_LENGTH;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TYPE:   window_type_reg   <= pwdata[2:0];
                REG_LENGTH: window_length_reg <= pwdata[LEN_W-1:0];
                default:    window_type_reg   <= window_type_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TYPE:   prdata = {29'b0, window_type_reg};
            REG_LENGTH: prdata = {19'b0, window_length_reg};
            default:    prdata = '0;
        endcase
    end

    // lengths beyond MAX_LENGTH saturate to MAX_LENGTH
    assign n_sat = (MAX_LENGTH < (1 << LEN_W) && 32'(window_length_reg) > MAX_LENGTH)
                 ? LEN_W'(MAX_LENGTH) : window_length_reg;

    // --- table builder; any register write starts a rebuild ---
    wcg_fill_engine #(
        .MAX_LENGTH (MAX_LENGTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_fill (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (cfg_wr),
        .window_type (window_type_reg),
        .length      (n_sat),
        .stat        (fill_stat),
        .wr_addr     (fill_addr),
        .wr_data     (fill_data)
    );

    // --- request pipeline: table read stage, then output register ---
    assign out_load    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign s1_free     = !s1_valid_reg || out_load;
    assign index_ready = !fill_stat.busy && s1_free;
    assign in_take     = index_valid && index_ready;

    always_ff @(posedge clk)
    begin
        if (fill_stat.wr_en)
            coef_mem[fill_addr] <= fill_data;
        if (in_take)
            ram_q <= coef_mem[sample_index[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_oor_reg <= ({1'b0, sample_index} >= n_sat);
        if (out_load)
        begin
            coefficient_reg <= s1_oor_reg ? '0 : ram_q;
            oor_reg         <= s1_oor_reg;
        end
    end

    assign result_valid       = result_valid_reg;
    assign coefficient        = coefficient_reg;
    assign index_out_of_range = oor_reg;

    // --- checks ---
    `WCG_ASSERT_NOW(a_no_take_in_fill, clk, rst_n, fill_stat.wr_en, !index_ready, "request taken during table rebuild")
    `WCG_ASSERT_NOW(a_oor_zero, clk, rst_n, result_valid && index_out_of_range, coefficient == '0, "out of range index gave a nonzero coefficient")
    `WCG_ASSERT_NOW(a_coef_bound, clk, rst_n, result_valid, coefficient <= ONE_OUT, "coefficient above 1.0")
    `WCG_ASSERT_NEXT(a_s1_load, clk, rst_n, in_take, s1_valid_reg, "taken request lost before read stage")

endmodule

>>> rtl/core/wcg_fill_engine.sv
// Coefficient table builder: computes one window coefficient per entry.
// Uses wcg_pkg; shared bit-serial divider, CORDIC, multiplier and isqrt.
module wcg_fill_engine
    import wcg_pkg::*;
#(
    parameter int MAX_LENGTH = 4096,
    parameter int FRAC_BITS  = 15,
    localparam int DEPTH     = (MAX_LENGTH < IDX_SPAN) ? MAX_LENGTH : IDX_SPAN,
    localparam int AW        = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    input  logic [2:0]       window_type,
    input  logic [LEN_W-1:0] length,
    output fill_stat_t       stat,
    output logic [AW-1:0]    wr_addr,
    output logic [FRAC_BITS:0] wr_data
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic [30:0] RND   = 31'((1 << SH) >> 1);
    localparam logic [30:0] ONE_W = 31'(1) << FRAC_BITS;

    fill_state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic pass_reg, pass_next;
    logic tri_reg, tri_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [13:0] den_reg, den_next;
    logic [13:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next, cos_reg, cos_next;
    logic signed [31:0] z_reg, z_next;
    logic [1:0] quad_reg, quad_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [VW-1:0] v_reg, v_next;
    logic [63:0] sq_v_reg, sq_v_next, sq_res_reg, sq_res_next, sq_bit_reg, sq_bit_next;

    logic [13:0] n_ext, n_m1, n_p1, tri_num, tri_den;
    logic [IDX_W-1:0] half, mirror, j_idx;
    logic tri_mid;
    logic [LEN_W-1:0] fcount;
    logic last_entry;

    logic [14:0] trial;
    logic d_ge;
    logic [13:0] d_rem;
    logic [DIV_W-1:0] d_quo;

    logic [4:0] ck;
    logic signed [33:0] c_dx, c_dy, c_cos;
    logic signed [31:0] c_at;
    logic signed [VW-1:0] hann_v, m_round;
    logic signed [31:0] mcoef;

    logic [63:0] s_sum, s_res;
    logic s_ge;

    logic [30:0] o_r;
    logic [FRAC_BITS:0] o_val;

    logic div_go, div_phase, sq_go, wr_en_c;
    logic [13:0] div_num, div_den;
    logic [30:0] sq_src;

    // Triangular window operands
    always_comb
    begin
        n_ext   = {1'b0, length};
        n_m1    = n_ext - 14'd1;
        n_p1    = n_ext + 14'd1;
        half    = length[LEN_W-1:1];
        mirror  = IDX_W'(length - 13'd1 - {1'b0, idx_reg});
        j_idx   = (idx_reg < half) ? idx_reg : mirror;
        tri_mid = (idx_reg == half);
        tri_num = {1'b0, j_idx, 1'b0} + (length[0] ? 14'd2 : 14'd1);
        tri_den = length[0] ? n_p1 : n_ext;
        fcount  = (length > LEN_W'(IDX_SPAN)) ? LEN_W'(IDX_SPAN) : length;
        last_entry = ({1'b0, idx_reg} == (fcount - 13'd1));
    end

    // Restoring divider step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        d_ge  = (trial >= {1'b0, den_reg});
        d_rem = d_ge ? 14'(trial - {1'b0, den_reg}) : trial[13:0];
        d_quo = {quo_reg[DIV_W-2:0], d_ge};
    end

    // CORDIC rotation step and quadrant fold
    always_comb
    begin
        ck   = cnt_reg[4:0];
        c_dx = y_reg >>> ck;
        c_dy = x_reg >>> ck;
        c_at = signed'({2'b00, atan_turn(ck)});
        case (quad_reg)
            2'd0:    c_cos = x_reg;
            2'd1:    c_cos = -y_reg;
            2'd2:    c_cos = -x_reg;
            default: c_cos = y_reg;
        endcase
        hann_v  = (ONE_Q30 - VW'(c_cos)) >>> 1;
        mcoef   = (window_type == WT_HAMMING) ? K_046 : (pass_reg ? K_008 : K_050);
        m_round = VW'((prod_reg + 66'sd536870912) >>> 30);
    end

    // Integer square root step
    always_comb
    begin
        s_sum = sq_res_reg + sq_bit_reg;
        s_ge  = (sq_v_reg >= s_sum);
        s_res = s_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
    end

    // Round to output precision and clamp to [0, 1.0]
    always_comb
    begin
        o_r = ({1'b0, v_reg[29:0]} + RND) >> SH;
        if (v_reg <= 0)
            o_val = '0;
        else if (v_reg >= ONE_Q30)
            o_val = ONE_W[FRAC_BITS:0];
        else if (o_r > ONE_W)
            o_val = ONE_W[FRAC_BITS:0];
        else
            o_val = o_r[FRAC_BITS:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pass_next   = pass_reg;
        tri_next    = tri_reg;
        cnt_next    = cnt_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        quad_next   = quad_reg;
        cos_next    = cos_reg;
        prod_next   = prod_reg;
        v_next      = v_reg;
        sq_v_next   = sq_v_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        div_go      = 1'b0;
        div_phase   = 1'b1;
        div_num     = '0;
        div_den     = '0;
        sq_go       = 1'b0;
        sq_src      = '0;
        wr_en_c     = 1'b0;

        case (state_reg)
            FS_IDLE:
            begin
                state_next = FS_IDLE;
            end
            FS_START:
            begin
                idx_next   = '0;
                state_next = (fcount == '0) ? FS_IDLE : FS_SETUP;
            end
            FS_SETUP:
            begin
                pass_next = 1'b0;
                case (window_type)
                    WT_HAMMING, WT_HANN, WT_BLACKMAN:
                    begin
                        if (length == 13'd1)
                        begin
                            v_next     = (window_type == WT_HAMMING) ? C_008 : ONE_Q30;
                            state_next = FS_WRITE;
                        end
                        else
                        begin
                            div_go  = 1'b1;
                            div_num = {2'b00, idx_reg};
                            div_den = n_m1;
                        end
                    end
                    WT_HANN_NZ:
                    begin
                        div_go  = 1'b1;
                        div_num = {2'b00, idx_reg} + 14'd1;
                        div_den = n_p1;
                    end
                    WT_TRI, WT_SQRT_TRI:
                    begin
                        if (length[0] && tri_mid)
                        begin
                            if (window_type == WT_SQRT_TRI)
                            begin
                                sq_go  = 1'b1;
                                sq_src = ONE_Q30[30:0];
                            end
                            else
                            begin
                                v_next     = ONE_Q30;
                                state_next = FS_WRITE;
                            end
                        end
                        else
                        begin
                            div_go    = 1'b1;
                            div_phase = 1'b0;
                            div_num   = tri_num;
                            div_den   = tri_den;
                        end
                    end
                    default:
                    begin
                        v_next     = '0;
                        state_next = FS_WRITE;
                    end
                endcase
            end
            FS_DIV:
            begin
                rem_next = d_rem;
                quo_next = d_quo;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_W - 1))
                begin
                    if (tri_reg)
                    begin
                        if (window_type == WT_SQRT_TRI)
                        begin
                            sq_go  = 1'b1;
                            sq_src = d_quo[30:0];
                        end
                        else
                        begin
                            v_next     = VW'({1'b0, d_quo[30:0]});
                            state_next = FS_WRITE;
                        end
                    end
                    else
                    begin
                        quad_next  = d_quo[31:30];
                        z_next     = {2'b00, d_quo[29:0]};
                        x_next     = CORDIC_GAIN_INV;
                        y_next     = '0;
                        cnt_next   = '0;
                        state_next = FS_CORDIC;
                    end
                end
            end
            FS_CORDIC:
            begin
                if (!z_reg[31])
                begin
                    x_next = x_reg - c_dx;
                    y_next = y_reg + c_dy;
                    z_next = z_reg - c_at;
                end
                else
                begin
                    x_next = x_reg + c_dx;
                    y_next = y_reg - c_dy;
                    z_next = z_reg + c_at;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd29)
                    state_next = FS_COS;
            end
            FS_COS:
            begin
                if (window_type == WT_HANN || window_type == WT_HANN_NZ)
                begin
                    v_next     = hann_v;
                    state_next = FS_WRITE;
                end
                else
                begin
                    cos_next   = c_cos;
                    state_next = FS_MUL;
                end
            end
            FS_MUL:
            begin
                prod_next  = mcoef * cos_reg;
                state_next = FS_ACC;
            end
            FS_ACC:
            begin
                if (window_type == WT_HAMMING)
                begin
                    v_next     = C_054 - m_round;
                    state_next = FS_WRITE;
                end
                else if (!pass_reg)
                begin
                    // first Blackman term done, second cosine runs at twice the phase
                    v_next    = C_042 - m_round;
                    pass_next = 1'b1;
                    div_go    = 1'b1;
                    div_num   = {1'b0, idx_reg, 1'b0};
                    div_den   = n_m1;
                end
                else
                begin
                    v_next     = v_reg + m_round;
                    state_next = FS_WRITE;
                end
            end
            FS_SQRT:
            begin
                if (s_ge)
                    sq_v_next = sq_v_reg - s_sum;
                sq_res_next = s_res;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    v_next     = VW'({1'b0, s_res[30:0]});
                    state_next = FS_WRITE;
                end
            end
            FS_WRITE:
            begin
                wr_en_c = 1'b1;
                if (last_entry)
                    state_next = FS_IDLE;
                else
                begin
                    idx_next   = idx_reg + 12'd1;
                    state_next = FS_SETUP;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase

        if (div_go)
        begin
            quo_next   = (DIV_W'(div_num) << (div_phase ? 32 : 30)) + DIV_W'(div_den >> 1);
            rem_next   = '0;
            den_next   = div_den;
            cnt_next   = '0;
            tri_next   = !div_phase;
            state_next = FS_DIV;
        end
        if (sq_go)
        begin
            sq_v_next   = 64'(sq_src) << 30;
            sq_res_next = '0;
            sq_bit_next = 64'h4000_0000_0000_0000;
            cnt_next    = '0;
            state_next  = FS_SQRT;
        end
        if (restart)
            state_next = FS_START;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_START;
            idx_reg   <= '0;
            pass_reg  <= 1'b0;
            tri_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            tri_reg   <= tri_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        quad_reg   <= quad_next;
        cos_reg    <= cos_next;
        prod_reg   <= prod_next;
        v_reg      <= v_next;
        sq_v_reg   <= sq_v_next;
        sq_res_reg <= sq_res_next;
        sq_bit_reg <= sq_bit_next;
    end

    assign stat    = '{busy: (state_reg != FS_IDLE), wr_en: wr_en_c};
    assign wr_addr = idx_reg[AW-1:0];
    assign wr_data = o_val;

endmodule
